@@ rtl/lnwq_pkg.sv @@
// ----------------------------------------------------------------------------
// lnwq_pkg
// shared types and constants for the lcd nibble write queue
// ----------------------------------------------------------------------------
package lnwq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam int POPQ_DEPTH = 4;
    localparam int POPQ_PTR_W = $clog2(POPQ_DEPTH);
    localparam int POPQ_CNT_W = $clog2(POPQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] NIBBLE_MASK    = 8'hF0;
    localparam logic [5:0] PAUSE_MASK     = 6'h3F;
    localparam int         NIBBLE_SHIFT   = 4;
    localparam logic [6:0] TICK_SAT       = 7'd127;

    localparam logic [7:0] RS_MASK_RST    = 8'd1;
    localparam logic [7:0] EN_MASK_RST    = 8'd4;
    localparam logic [7:0] BL_MASK_RST    = 8'd8;
    localparam logic       BL_ON_RST      = 1'b1;

    localparam logic CMD_ENQ  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RS_MASK    = 2'd0,
        CFG_EN_MASK    = 2'd1,
        CFG_BL_MASK    = 2'd2,
        CFG_BL_ON      = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic       cmd;
        logic [7:0] lcd_byte;
        logic       is_data;
        logic       half_only;
        logic [5:0] pause_ticks;
    } in_t;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [5:0] pause;
        logic       half_only;
        logic       is_data;
        logic [7:0] lcd_byte;
    } entry_t;

    typedef struct packed {
        logic       half_only;
        logic       is_data;
        logic [7:0] lcd_byte;
    } job_t;

    typedef struct packed {
        logic                  valid;
        logic [POPQ_CNT_W-1:0] count;
    } popq_status_t;

endpackage

@@ rtl/lcd_nibble_write_queue.sv @@
// ----------------------------------------------------------------------------
// lcd_nibble_write_queue
// queues lcd writes and turns them into 4-bit expander byte streams
// ----------------------------------------------------------------------------
// in channel: one item per transfer, either an lcd byte to enqueue or a
// one millisecond tick. an item that pops no entry leaves in_ready high,
// so such items may follow back to back. an item that pops an entry holds
// in_ready low while the entry is read from the ring memory (one registered
// read port), so the next item waits until that read is through.
// out channel: one expander byte per transfer, last set on the final byte
// of an entry. an entry gives 4 bytes (2 for half-only) back to back unless
// the receiver stalls. a popped entry passes the ring address and data
// registers, then waits in a 4-entry queue ahead of the output. when the
// receiver stalls, the output byte holds; once the queue fills, in_ready
// drops until bytes drain. config writes take effect at once; the user must
// write them only while the block is idle; the block does not enforce it.
// reset: ring, pause timer, queue and output are empty, masks take their
// default values. the ring memory needs no clearing.
// ----------------------------------------------------------------------------
module lcd_nibble_write_queue #(
    parameter int QUEUE_DEPTH = lnwq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  lnwq_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lnwq_pkg::out_t                   out_data,
    input  logic                             cfg_wr_en,
    input  logic [lnwq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lnwq_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import lnwq_pkg::*;

    popq_status_t q_status;
    job_t         push_data;
    job_t         q_head;
    logic         push;
    logic         q_pop;

    lnwq_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    lnwq_pop_queue u_pop_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (q_pop),
        .status    (q_status),
        .head      (q_head)
    );

    lnwq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

@@ rtl/lnwq_front.sv @@
// ----------------------------------------------------------------------------
// lnwq_front
// accepts enqueue and tick items, keeps the entry ring and the pause timer,
// decides pops and reads popped entries out of the ring
// ----------------------------------------------------------------------------
module lnwq_front #(
    parameter int QUEUE_DEPTH = lnwq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lnwq_pkg::in_t         in_data,
    input  lnwq_pkg::popq_status_t q_status,
    output logic                  push,
    output lnwq_pkg::job_t        push_data
);
    import lnwq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t mem [QUEUE_DEPTH];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]       pause_reg, pause_next;
    logic [6:0]       elapsed_reg, elapsed_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             data_vld_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    entry_t           rd_data_reg;

    logic             accept;
    logic             enq;
    logic             pop;
    logic [6:0]       elapsed_after;
    logic [CNT_W-1:0] count_after;
    entry_t           wr_entry;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign in_ready = !rd_vld_reg && !data_vld_reg
                   && (q_status.count < POPQ_CNT_W'(POPQ_DEPTH));
    assign accept   = in_valid && in_ready;

    assign wr_entry.pause     = in_data.pause_ticks & PAUSE_MASK;
    assign wr_entry.half_only = in_data.half_only;
    assign wr_entry.is_data   = in_data.is_data;
    assign wr_entry.lcd_byte  = in_data.lcd_byte;

    always_comb
    begin
        enq = (in_data.cmd == CMD_ENQ) && (count_reg < CNT_W'(QUEUE_DEPTH));
        if ((in_data.cmd == CMD_TICK) && (elapsed_reg != TICK_SAT))
        begin
            elapsed_after = elapsed_reg + 7'd1;
        end
        else
        begin
            elapsed_after = elapsed_reg;
        end
        count_after = count_reg + CNT_W'(enq);
        pop = (count_after != '0)
           && !((pause_reg != '0) && (elapsed_after <= {1'b0, pause_reg}));

        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        pause_next   = pause_reg;
        rd_vld_next  = 1'b0;
        if (accept)
        begin
            if (enq)
            begin
                tail_next = ring_next(tail_reg);
            end
            count_next   = count_after;
            elapsed_next = elapsed_after;
            if (pop)
            begin
                head_next    = ring_next(head_reg);
                count_next   = count_after - 1'b1;
                elapsed_next = '0;
                rd_vld_next  = 1'b1;
            end
        end
        if (data_vld_reg)
        begin
            pause_next = rd_data_reg.pause;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            pause_reg    <= '0;
            elapsed_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            data_vld_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            pause_reg    <= pause_next;
            elapsed_reg  <= elapsed_next;
            rd_vld_reg   <= rd_vld_next;
            data_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && enq)
        begin
            mem[tail_reg] <= wr_entry;
        end
        if (rd_vld_next)
        begin
            rd_addr_reg <= head_reg;
        end
        if (rd_vld_reg)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    assign push                = data_vld_reg;
    assign push_data.half_only = rd_data_reg.half_only;
    assign push_data.is_data   = rd_data_reg.is_data;
    assign push_data.lcd_byte  = rd_data_reg.lcd_byte;

endmodule

@@ rtl/lnwq_pop_queue.sv @@
// ----------------------------------------------------------------------------
// lnwq_pop_queue
// short queue of popped entries between front and back
// ----------------------------------------------------------------------------
module lnwq_pop_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lnwq_pkg::job_t         push_data,
    input  logic                   pop,
    output lnwq_pkg::popq_status_t status,
    output lnwq_pkg::job_t         head
);
    import lnwq_pkg::*;

    job_t q_mem [POPQ_DEPTH];

    logic [POPQ_PTR_W-1:0] wr_ptr_reg;
    logic [POPQ_PTR_W-1:0] rd_ptr_reg;
    logic [POPQ_CNT_W-1:0] count_reg, count_next;
    logic                  do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign status.valid = (count_reg != '0);
    assign status.count = count_reg;
    assign head         = q_mem[rd_ptr_reg];

endmodule

@@ rtl/lnwq_back.sv @@
// ----------------------------------------------------------------------------
// lnwq_back
// holds the mask registers and expands each popped entry into expander bytes
// ----------------------------------------------------------------------------
module lnwq_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lnwq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lnwq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  lnwq_pkg::popq_status_t           q_status,
    input  lnwq_pkg::job_t                   q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output lnwq_pkg::out_t                   out_data
);
    import lnwq_pkg::*;

    logic [7:0] rs_mask_reg;
    logic [7:0] en_mask_reg;
    logic [7:0] bl_mask_reg;
    logic       bl_on_reg;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_data_reg;

    logic       load;
    logic       is_last;
    logic [7:0] byte_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_mask_reg <= RS_MASK_RST;
            en_mask_reg <= EN_MASK_RST;
            bl_mask_reg <= BL_MASK_RST;
            bl_on_reg   <= BL_ON_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_RS_MASK: rs_mask_reg <= cfg_wr_data;
                CFG_EN_MASK: en_mask_reg <= cfg_wr_data;
                CFG_BL_MASK: bl_mask_reg <= cfg_wr_data;
                CFG_BL_ON:   bl_on_reg   <= cfg_wr_data[0];
            endcase
        end
    end

    always_comb
    begin
        load    = q_status.valid && (!out_valid_reg || out_ready);
        is_last = (q_head.half_only && (idx_reg == 2'd1)) || (idx_reg == 2'd3);

        if (idx_reg[1] == 1'b0)
        begin
            byte_val = q_head.lcd_byte & NIBBLE_MASK;
        end
        else
        begin
            byte_val = (q_head.lcd_byte << NIBBLE_SHIFT) & NIBBLE_MASK;
        end
        if (q_head.is_data)
        begin
            byte_val = byte_val | rs_mask_reg;
        end
        if (idx_reg[0] == 1'b0)
        begin
            byte_val = byte_val | en_mask_reg;
        end
        if (bl_on_reg)
        begin
            byte_val = byte_val | bl_mask_reg;
        end

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.expander_byte <= byte_val;
            out_data_reg.last          <= is_last;
        end
    end

    assign q_pop     = load && is_last;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/lnwq_checker.sv @@
// ----------------------------------------------------------------------------
// lnwq_checker
// port-level checks on the expander byte stream
// ----------------------------------------------------------------------------
module lnwq_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           out_valid,
    input  logic           out_ready,
    input  lnwq_pkg::out_t out_data
);
    import lnwq_pkg::*;

    logic [1:0] pos_reg;
    logic       out_xfer;

    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (out_xfer)
        begin
            pos_reg <= out_data.last ? 2'd0 : pos_reg + 2'd1;
        end
    end

    // stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output byte changed while stalled");

    // an entry ends after two or four bytes
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && out_data.last |-> (pos_reg == 2'd1 || pos_reg == 2'd3))
        else $error("last flag at odd position in entry");

    a_fourth_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && (pos_reg == 2'd3) |-> out_data.last)
        else $error("entry longer than four bytes");

    // output is empty while reset is held
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind lcd_nibble_write_queue lnwq_checker u_lnwq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ tb/lnwq_byte_checker.sv @@
// ----------------------------------------------------------------------------
// lnwq_byte_checker
// watches the item, byte and config ports of the lcd nibble write queue,
// keeps its own copy of the ring, pause timer and masks, expands every
// popped entry into the expected expander bytes and compares each byte
// transfer against the oldest expected byte
// ----------------------------------------------------------------------------
module lnwq_byte_checker
    import lnwq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_t                  out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output int                    fail_count,
    output int                    bytes_pending,
    output int                    queued_entries
);
    timeunit 1ns;
    timeprecision 1ps;

    entry_t     ring [DEPTH];
    int         wr_ptr;
    int         rd_ptr;
    int         fill;
    logic [5:0] hold_ticks;
    logic [6:0] since_pop;

    logic [7:0] rs_pat;
    logic [7:0] en_pat;
    logic [7:0] bl_pat;
    logic       bl_on;

    out_t       want_bytes [$];
    int         errs = 0;

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t mismatch %s: expected %02h got %02h", $time, what, want, got);
        errs++;
    endtask

    task automatic predict_bytes(input in_t item);
        entry_t     e;
        logic [7:0] b;
        out_t       o;
        int         n;
        if (item.cmd == CMD_ENQ)
        begin
            if (fill < DEPTH)
            begin
                e.pause     = item.pause_ticks;
                e.half_only = item.half_only;
                e.is_data   = item.is_data;
                e.lcd_byte  = item.lcd_byte;
                ring[wr_ptr] = e;
                wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
                fill++;
            end
        end
        else if (since_pop < TICK_SAT)
        begin
            since_pop++;
        end
        if (fill == 0)
            return;
        if (hold_ticks != 0 && since_pop <= {1'b0, hold_ticks})
            return;
        e = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
        fill--;
        hold_ticks = e.pause;
        since_pop  = '0;
        n = e.half_only ? 2 : 4;
        for (int i = 0; i < n; i++)
        begin
            b = (i < 2) ? {e.lcd_byte[7:4], 4'h0} : {e.lcd_byte[3:0], 4'h0};
            if (e.is_data)
                b |= rs_pat;
            if (i % 2 == 0)
                b |= en_pat;
            if (bl_on)
                b |= bl_pat;
            o.expander_byte = b;
            o.last          = (i == n - 1);
            want_bytes.push_back(o);
        end
    endtask

    task automatic check_byte();
        out_t w;
        if (want_bytes.size() == 0)
        begin
            report_mismatch("unexpected byte", 8'h00, out_data.expander_byte);
        end
        else
        begin
            w = want_bytes.pop_front();
            if (out_data.expander_byte !== w.expander_byte)
                report_mismatch("expander_byte", w.expander_byte, out_data.expander_byte);
            if (out_data.last !== w.last)
                report_mismatch("last", {7'd0, w.last}, {7'd0, out_data.last});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr     = 0;
            rd_ptr     = 0;
            fill       = 0;
            hold_ticks = '0;
            since_pop  = '0;
            rs_pat     = RS_MASK_RST;
            en_pat     = EN_MASK_RST;
            bl_pat     = BL_MASK_RST;
            bl_on      = BL_ON_RST;
            errs       = 0;
            want_bytes.delete();
            fail_count     <= 0;
            bytes_pending  <= 0;
            queued_entries <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_idx_e'(cfg_index))
                    CFG_RS_MASK: rs_pat = cfg_wr_data;
                    CFG_EN_MASK: en_pat = cfg_wr_data;
                    CFG_BL_MASK: bl_pat = cfg_wr_data;
                    CFG_BL_ON:   bl_on  = cfg_wr_data[0];
                    default:     ;
                endcase
            end
            if (out_valid && out_ready)
                check_byte();
            if (in_valid && in_ready)
                predict_bytes(in_data);
            fail_count     <= errs;
            bytes_pending  <= want_bytes.size();
            queued_entries <= fill;
        end
    end

endmodule

@@ tb/lcd_nibble_write_queue_tb.sv @@
// ----------------------------------------------------------------------------
// lcd_nibble_write_queue_tb
// drives enqueue and tick items into the lcd nibble write queue under
// several mask settings, with random gaps and stalls on both channels and
// one long receiver hold-off; the byte checker predicts and compares
// ----------------------------------------------------------------------------
module lcd_nibble_write_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lnwq_pkg::*;

    localparam int DEPTH           = QUEUE_DEPTH_DEFAULT;
    localparam int RESET_CYCLES    = 11;
    localparam int TAIL_CYCLES     = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 20;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int   fail_count;
    int   bytes_pending;
    int   queued_entries;
    logic steady = 1'b0;
    int   hold_seq = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lcd_nibble_write_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    lnwq_byte_checker #(
        .DEPTH (DEPTH)
    ) u_byte_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .fail_count     (fail_count),
        .bytes_pending  (bytes_pending),
        .queued_entries (queued_entries)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic in_t mk_entry(input logic [7:0] lcd_byte, input logic is_data,
                                     input logic half_only, input logic [5:0] pause);
        in_t it;
        it.cmd         = CMD_ENQ;
        it.lcd_byte    = lcd_byte;
        it.is_data     = is_data;
        it.half_only   = half_only;
        it.pause_ticks = pause;
        return it;
    endfunction

    function automatic in_t mk_tick();
        in_t it;
        it.cmd         = CMD_TICK;
        it.lcd_byte    = 8'($urandom_range(0, 255));
        it.is_data     = 1'($urandom_range(0, 1));
        it.half_only   = 1'($urandom_range(0, 1));
        it.pause_ticks = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic logic [5:0] rand_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 6'd0;
        else if (r < 97)
            return 6'($urandom_range(1, 4));
        return 6'($urandom_range(5, 63));
    endfunction

    function automatic in_t rand_entry(input logic [5:0] pause);
        return mk_entry(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), pause);
    endfunction

    function automatic in_t rand_item(input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct)
            return mk_tick();
        return rand_entry(rand_pause());
    endfunction

    // entered just after a rising edge; returns just after the transfer edge
    task automatic send_item(input in_t it);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (queued_entries != 0)
            send_item(mk_tick());
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] rs, input logic [7:0] en,
                                input logic [7:0] bl, input logic on);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_RS_MASK;
        cfg_wr_data <= rs;
        @(posedge clk);
        cfg_index   <= CFG_EN_MASK;
        cfg_wr_data <= en;
        @(posedge clk);
        cfg_index   <= CFG_BL_MASK;
        cfg_wr_data <= bl;
        @(posedge clk);
        cfg_index   <= CFG_BL_ON;
        cfg_wr_data <= {7'($urandom_range(0, 127)), on};
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        @(posedge clk);
    endtask

    // receiver: random stalls, a long hold-off on request
    initial
    begin
        int seen;
        int stall;
        seen = 0;
        @(posedge clk);
        forever
        begin
            if (hold_seq != seen)
            begin
                seen = hold_seq;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [7:0] rs;
        logic [7:0] en;
        logic [7:0] bl;
        logic       on;
        int         tick_pct;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset masks, extremes of byte and pause
        send_item(mk_tick());
        send_item(mk_entry(8'h00, 1'b0, 1'b0, 6'd0));
        send_item(mk_entry(8'hFF, 1'b1, 1'b0, 6'd0));
        send_item(mk_entry(8'hA5, 1'b1, 1'b1, 6'd0));
        send_item(mk_entry(8'h3C, 1'b0, 1'b1, 6'd2));
        send_item(mk_entry(8'h81, 1'b1, 1'b0, 6'd63));
        repeat (3) send_item(mk_tick());
        // tick count saturates, then a new entry pops in the same transfer
        repeat (130) send_item(mk_tick());
        send_item(mk_entry(8'h7E, 1'b0, 1'b0, 6'd0));
        // fill the ring across the wrap, one more entry is dropped
        send_item(mk_entry(8'hC3, 1'b1, 1'b0, 6'd1));
        repeat (DEPTH + 1)
            send_item(rand_entry(rand_pause()));
        drain_block();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    rs = 8'h00; en = 8'h00; bl = 8'h00; on = 1'b0;
                end
                1:
                begin
                    rs = 8'hFF; en = 8'hFF; bl = 8'hFF; on = 1'b1;
                end
                4:
                begin
                    rs = RS_MASK_RST; en = EN_MASK_RST; bl = BL_MASK_RST; on = BL_ON_RST;
                end
                default:
                begin
                    rs = 8'($urandom_range(0, 255));
                    en = 8'($urandom_range(0, 255));
                    bl = 8'($urandom_range(0, 255));
                    on = p[0];
                end
            endcase
            write_config(rs, en, bl, on);
            steady <= (p == 2);
            @(posedge clk);

            if (p == 3)
            begin
                repeat (64) send_item(mk_tick());
                hold_seq <= hold_seq + 1;
                repeat (30)
                    send_item(rand_entry(6'd0));
            end

            tick_pct = $urandom_range(1, 7) * 10;
            repeat (ITEMS_PER_PHASE)
                send_item(rand_item(tick_pct));
            drain_block();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ lcd_nibble_write_queue.f @@
rtl/lnwq_pkg.sv
rtl/lnwq_front.sv
rtl/lnwq_pop_queue.sv
rtl/lnwq_back.sv
rtl/lcd_nibble_write_queue.sv
rtl/lnwq_checker.sv
tb/lnwq_byte_checker.sv
tb/lcd_nibble_write_queue_tb.sv
